// File: rtl/core/pocs_pkg.sv
package pocs_pkg;

  localparam int unsigned REG_W = 16;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_BEGIN = 2'd1;
  localparam logic [1:0] REQ_CLICK = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  // Action codes
  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_BEGIN      = 3'd1;
  localparam logic [2:0] ACT_BLINK      = 3'd2;
  localparam logic [2:0] ACT_OK         = 3'd3;
  localparam logic [2:0] ACT_ERROR      = 3'd4;
  localparam logic [2:0] ACT_POWER_DOWN = 3'd5;
  localparam logic [2:0] ACT_RESTORE    = 3'd6;

  // Phase codes as reported on the result channel
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_RELEASE = 3'd1;
  localparam logic [2:0] PH_CLICK1  = 3'd2;
  localparam logic [2:0] PH_CLICK2  = 3'd3;
  localparam logic [2:0] PH_CLICK3  = 3'd4;
  localparam logic [2:0] PH_FINAL   = 3'd5;
  localparam logic [2:0] PH_FAIL    = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIN_LOW  = 2'd0;
  localparam logic [1:0] CFG_WIN_HIGH = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd2;
  localparam logic [1:0] CFG_OFF_DLY  = 2'd3;

  localparam logic [REG_W-1:0] WIN_LOW_RST  = 16'd1400;
  localparam logic [REG_W-1:0] WIN_HIGH_RST = 16'd1800;
  localparam logic [REG_W-1:0] TIMEOUT_RST  = 16'd4000;
  localparam logic [REG_W-1:0] OFF_DLY_RST  = 16'd2000;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_RELEASE = 7'b0000010,
    ST_CLICK1  = 7'b0000100,
    ST_CLICK2  = 7'b0001000,
    ST_CLICK3  = 7'b0010000,
    ST_FINAL   = 7'b0100000,
    ST_FAIL    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       button_pressed;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] phase_out;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] window_low_ms;
    logic [REG_W-1:0] window_high_ms;
    logic [REG_W-1:0] timeout_ms;
    logic [REG_W-1:0] off_delay_ms;
  } cfg_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    unique case (ph)
      ST_IDLE:    code = PH_IDLE;
      ST_RELEASE: code = PH_RELEASE;
      ST_CLICK1:  code = PH_CLICK1;
      ST_CLICK2:  code = PH_CLICK2;
      ST_CLICK3:  code = PH_CLICK3;
      ST_FINAL:   code = PH_FINAL;
      ST_FAIL:    code = PH_FAIL;
      default:    code = PH_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/pocs_cfg.sv
module pocs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [pocs_pkg::REG_W-1:0]     cfg_wdata,
  output pocs_pkg::cfg_t                 cfg
);

  pocs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_low_ms  <= pocs_pkg::WIN_LOW_RST;
      cfg_r.window_high_ms <= pocs_pkg::WIN_HIGH_RST;
      cfg_r.timeout_ms     <= pocs_pkg::TIMEOUT_RST;
      cfg_r.off_delay_ms   <= pocs_pkg::OFF_DLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pocs_pkg::CFG_WIN_LOW:  cfg_r.window_low_ms  <= cfg_wdata;
        pocs_pkg::CFG_WIN_HIGH: cfg_r.window_high_ms <= cfg_wdata;
        pocs_pkg::CFG_TIMEOUT:  cfg_r.timeout_ms     <= cfg_wdata;
        pocs_pkg::CFG_OFF_DLY:  cfg_r.off_delay_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/pocs_seq.sv
module pocs_seq #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  pocs_pkg::in_item_t  in_item,
  input  pocs_pkg::cfg_t      cfg,
  output pocs_pkg::out_item_t result
);

  localparam int unsigned CMP_W = (TIMER_BITS > pocs_pkg::REG_W) ? TIMER_BITS : pocs_pkg::REG_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  pocs_pkg::phase_t        phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic [TIMER_BITS-1:0]   elapsed_inc;
  logic [CMP_W-1:0]        inc_x, cur_x;
  logic                    tmo_hit, off_hit, win_ok;
  logic [2:0]              act;

  // saturating millisecond count
  assign elapsed_inc = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + TIMER_BITS'(1);
  assign inc_x       = CMP_W'(elapsed_inc);
  assign cur_x       = CMP_W'(elapsed_r);
  assign tmo_hit     = inc_x >= CMP_W'(cfg.timeout_ms);
  assign off_hit     = inc_x >= CMP_W'(cfg.off_delay_ms);
  assign win_ok      = (cur_x > CMP_W'(cfg.window_low_ms)) &&
                       (cur_x < CMP_W'(cfg.window_high_ms));

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    act         = pocs_pkg::ACT_NONE;
    if (accept) begin
      unique case (in_item.req_type)
        pocs_pkg::REQ_TICK: begin
          unique case (phase_r)
            pocs_pkg::ST_RELEASE: begin
              elapsed_nxt = elapsed_inc;
              if (!in_item.button_pressed) begin
                phase_nxt   = pocs_pkg::ST_CLICK1;
                elapsed_nxt = '0;
                act         = pocs_pkg::ACT_BLINK;
              end else if (tmo_hit) begin
                phase_nxt   = pocs_pkg::ST_FAIL;
                elapsed_nxt = '0;
                act         = pocs_pkg::ACT_ERROR;
              end
            end
            pocs_pkg::ST_CLICK1, pocs_pkg::ST_CLICK2, pocs_pkg::ST_CLICK3: begin
              elapsed_nxt = elapsed_inc;
              if (tmo_hit) begin
                phase_nxt   = pocs_pkg::ST_FAIL;
                elapsed_nxt = '0;
                act         = pocs_pkg::ACT_ERROR;
              end
            end
            pocs_pkg::ST_FINAL: begin
              elapsed_nxt = elapsed_inc;
              if (off_hit) begin
                phase_nxt   = pocs_pkg::ST_IDLE;
                elapsed_nxt = '0;
                act         = pocs_pkg::ACT_POWER_DOWN;
              end
            end
            pocs_pkg::ST_FAIL: begin
              elapsed_nxt = elapsed_inc;
              if (tmo_hit) begin
                phase_nxt   = pocs_pkg::ST_IDLE;
                elapsed_nxt = '0;
                act         = pocs_pkg::ACT_RESTORE;
              end
            end
            default: ;
          endcase
        end
        pocs_pkg::REQ_BEGIN: begin
          if (phase_r == pocs_pkg::ST_IDLE) begin
            phase_nxt   = pocs_pkg::ST_RELEASE;
            elapsed_nxt = '0;
            act         = pocs_pkg::ACT_BEGIN;
          end
        end
        pocs_pkg::REQ_CLICK: begin
          if (phase_r == pocs_pkg::ST_CLICK1 || phase_r == pocs_pkg::ST_CLICK2 ||
              phase_r == pocs_pkg::ST_CLICK3) begin
            elapsed_nxt = '0;
            if (!win_ok) begin
              phase_nxt = pocs_pkg::ST_FAIL;
              act       = pocs_pkg::ACT_ERROR;
            end else if (phase_r == pocs_pkg::ST_CLICK3) begin
              phase_nxt = pocs_pkg::ST_FINAL;
              act       = pocs_pkg::ACT_OK;
            end else begin
              phase_nxt = (phase_r == pocs_pkg::ST_CLICK1) ? pocs_pkg::ST_CLICK2
                                                           : pocs_pkg::ST_CLICK3;
              act       = pocs_pkg::ACT_BLINK;
            end
          end
        end
        pocs_pkg::REQ_RSVD: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= pocs_pkg::ST_IDLE;
      elapsed_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign result.action    = act;
  assign result.phase_out = pocs_pkg::phase_code(phase_nxt);

endmodule

// File: rtl/core/pocs_obuf.sv
module pocs_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  pocs_pkg::out_item_t wr_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output pocs_pkg::out_item_t out_item
);

  pocs_pkg::out_item_t buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_en;

  assign rd_en     = out_valid && !out_stall;
  assign out_valid = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;
  assign out_item  = buf_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/power_off_click_sequence_top.sv
// Guarded power-off click sequencer.
// Input channel (in_valid / in_stall / in_item): one transaction is a tick,
// a begin request or a click; every accepted transaction yields exactly one
// result transaction (out_valid / out_stall / out_item) carrying the action
// and the phase after that transaction.
// Configuration (cfg_we / cfg_index / cfg_wdata) writes the window, timeout
// and off-delay registers; write them only while no transaction is in flight.
// Each result is registered into the output buffer on acceptance and offered from there on out_valid.
// One transaction is accepted per cycle while in_stall is low; the phase and
// timer update feeds a two-entry output buffer.
// When the receiver stalls, the buffer absorbs one more result; in_stall
// rises only while both buffer entries are occupied.
// Reset (rst_n low, synchronous): phase returns to idle, the timer clears,
// registers take their default values and the output buffer empties.
module power_off_click_sequence_top #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pocs_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pocs_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [pocs_pkg::REG_W-1:0]     cfg_wdata
);

  pocs_pkg::cfg_t      cfg;
  pocs_pkg::out_item_t result;
  logic                accept;
  logic                full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  pocs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pocs_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .cfg     (cfg),
    .result  (result)
  );

  pocs_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept),
    .wr_item   (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: rtl/core/pocs_chk.sv
module pocs_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pocs_pkg::out_item_t out_item
);

  // every accepted transaction must produce a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after accepted transaction");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_pd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.action == pocs_pkg::ACT_POWER_DOWN |->
      out_item.phase_out == pocs_pkg::PH_IDLE)
    else $error("power down without returning to idle");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped under stall");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("out_item changed under stall");

endmodule

bind power_off_click_sequence_top pocs_chk u_pocs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: sim/power_off_click_sequence_top_tb.sv
`timescale 1ns / 1ps

module power_off_click_sequence_top_tb;

  localparam int CYCLE_LIMIT = 50000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] elapsed;
  } seq_state_t;

  typedef struct packed {
    seq_state_t          st;
    pocs_pkg::out_item_t res;
  } seq_step_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  pocs_pkg::in_item_t         in_item = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  pocs_pkg::out_item_t        out_item;
  logic                       cfg_we = 1'b0;
  logic [1:0]                 cfg_index = pocs_pkg::CFG_WIN_LOW;
  logic [pocs_pkg::REG_W-1:0] cfg_wdata = '0;

  pocs_pkg::cfg_t regs = '{pocs_pkg::WIN_LOW_RST, pocs_pkg::WIN_HIGH_RST,
                           pocs_pkg::TIMEOUT_RST, pocs_pkg::OFF_DLY_RST};
  seq_state_t          plan_state = '0;
  seq_state_t          accepted_state = '0;
  pocs_pkg::in_item_t  pending_items[$];
  pocs_pkg::out_item_t expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  power_off_click_sequence_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Next phase, timer and result of the sequencer for one transaction.
  function automatic seq_step_t sequencer_next(seq_state_t cur, pocs_pkg::in_item_t it,
                                               pocs_pkg::cfg_t r);
    seq_step_t  s;
    logic [2:0] act;
    s.st = cur;
    act = pocs_pkg::ACT_NONE;
    if (s.st.phase > pocs_pkg::PH_FAIL) s.st.phase = pocs_pkg::PH_IDLE;
    case (it.req_type)
      pocs_pkg::REQ_TICK: begin
        if (s.st.phase != pocs_pkg::PH_IDLE) begin
          if (s.st.elapsed != '1) s.st.elapsed = s.st.elapsed + 16'd1;
          case (s.st.phase)
            pocs_pkg::PH_RELEASE: begin
              if (!it.button_pressed) begin
                s.st.phase = pocs_pkg::PH_CLICK1;
                s.st.elapsed = '0;
                act = pocs_pkg::ACT_BLINK;
              end else if (s.st.elapsed >= r.timeout_ms) begin
                s.st.phase = pocs_pkg::PH_FAIL;
                s.st.elapsed = '0;
                act = pocs_pkg::ACT_ERROR;
              end
            end
            pocs_pkg::PH_CLICK1, pocs_pkg::PH_CLICK2, pocs_pkg::PH_CLICK3: begin
              if (s.st.elapsed >= r.timeout_ms) begin
                s.st.phase = pocs_pkg::PH_FAIL;
                s.st.elapsed = '0;
                act = pocs_pkg::ACT_ERROR;
              end
            end
            pocs_pkg::PH_FINAL: begin
              if (s.st.elapsed >= r.off_delay_ms) begin
                s.st.phase = pocs_pkg::PH_IDLE;
                s.st.elapsed = '0;
                act = pocs_pkg::ACT_POWER_DOWN;
              end
            end
            default: begin
              if (s.st.elapsed >= r.timeout_ms) begin
                s.st.phase = pocs_pkg::PH_IDLE;
                s.st.elapsed = '0;
                act = pocs_pkg::ACT_RESTORE;
              end
            end
          endcase
        end
      end
      pocs_pkg::REQ_BEGIN: begin
        if (s.st.phase == pocs_pkg::PH_IDLE) begin
          s.st.phase = pocs_pkg::PH_RELEASE;
          s.st.elapsed = '0;
          act = pocs_pkg::ACT_BEGIN;
        end
      end
      pocs_pkg::REQ_CLICK: begin
        if (s.st.phase >= pocs_pkg::PH_CLICK1 && s.st.phase <= pocs_pkg::PH_CLICK3) begin
          if (s.st.elapsed > r.window_low_ms && s.st.elapsed < r.window_high_ms) begin
            s.st.phase = s.st.phase + 3'd1;
            act = (s.st.phase == pocs_pkg::PH_FINAL) ? pocs_pkg::ACT_OK
                                                     : pocs_pkg::ACT_BLINK;
          end else begin
            s.st.phase = pocs_pkg::PH_FAIL;
            act = pocs_pkg::ACT_ERROR;
          end
          s.st.elapsed = '0;
        end
      end
      default: ;
    endcase
    s.res.action = act;
    s.res.phase_out = s.st.phase;
    return s;
  endfunction

  // Queue one transaction; returns 1 when it does more than get ignored.
  function automatic bit push_item(logic [1:0] req, logic btn);
    pocs_pkg::in_item_t it;
    seq_step_t          s;
    bit                 moved;
    it.req_type = req;
    it.button_pressed = btn;
    s = sequencer_next(plan_state, it, regs);
    moved = (s.st != plan_state) || (s.res.action != pocs_pkg::ACT_NONE);
    plan_state = s.st;
    pending_items.push_back(it);
    return moved;
  endfunction

  task automatic push_ticks(input int n, input logic btn);
    repeat (n) void'(push_item(pocs_pkg::REQ_TICK, btn));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Tick the sequence back to idle, then let everything land.
  task automatic drain_to_idle();
    while (plan_state.phase != pocs_pkg::PH_IDLE)
      void'(push_item(pocs_pkg::REQ_TICK, 1'b0));
    wait_drained();
  endtask

  task automatic write_regs(input logic [15:0] lo, hi, lim, dly);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= pocs_pkg::CFG_WIN_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= pocs_pkg::CFG_WIN_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= pocs_pkg::CFG_TIMEOUT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_index <= pocs_pkg::CFG_OFF_DLY;
    cfg_wdata <= dly;
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = '{lo, hi, lim, dly};
    @(negedge clk);
  endtask

  // Mostly well-formed click sequences with random timing, plus noise.
  task automatic run_random(input int n);
    int         made;
    int         r;
    logic [1:0] req;
    logic       btn;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      btn = 1'($urandom_range(1));
      if (r < 8) begin
        req = 2'($urandom_range(3));
      end else begin
        case (plan_state.phase)
          pocs_pkg::PH_IDLE: req = pocs_pkg::REQ_BEGIN;
          pocs_pkg::PH_RELEASE: begin
            req = pocs_pkg::REQ_TICK;
            btn = (r < 70);
          end
          pocs_pkg::PH_CLICK1, pocs_pkg::PH_CLICK2, pocs_pkg::PH_CLICK3: begin
            if (plan_state.elapsed > regs.window_low_ms &&
                plan_state.elapsed < regs.window_high_ms)
              req = (r < 55) ? pocs_pkg::REQ_CLICK : pocs_pkg::REQ_TICK;
            else if (plan_state.elapsed <= regs.window_low_ms)
              req = (r < 14) ? pocs_pkg::REQ_CLICK : pocs_pkg::REQ_TICK;
            else
              req = (r < 50) ? pocs_pkg::REQ_CLICK : pocs_pkg::REQ_TICK;
          end
          default: req = pocs_pkg::REQ_TICK;
        endcase
      end
      if (push_item(req, btn)) made++;
    end
  endtask

  // Driver: advance the pending queue whenever the slot is free.
  always @(posedge clk) begin : drive_items
    seq_step_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      accepted_state = '0;
    end else begin
      if (in_valid && !in_stall) begin
        s = sequencer_next(accepted_state, in_item, regs);
        accepted_state = s.st;
        expected_results.push_back(s.res);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    pocs_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: action %0d phase %0d",
                   out_item.action, out_item.phase_out);
      end else begin
        want = expected_results.pop_front();
        if (out_item.action !== want.action || out_item.phase_out !== want.phase_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: action exp %0d got %0d, phase exp %0d got %0d",
                     want.action, out_item.action, want.phase_out, out_item.phase_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** power_off_click_sequence_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int lo;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 46;

    // Reset values: ignored click, release, then a click far too early.
    void'(push_item(pocs_pkg::REQ_BEGIN, 1'b1));
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b1));
    push_ticks(2, 1'b1);
    void'(push_item(pocs_pkg::REQ_TICK, 1'b0));
    push_ticks(3, 1'b1);
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b0));
    wait_drained();

    // Short directed run: ignored requests, window edges, a full sequence.
    write_regs(2, 5, 8, 3);
    drain_to_idle();
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b1));
    void'(push_item(pocs_pkg::REQ_RSVD, 1'b1));
    void'(push_item(pocs_pkg::REQ_TICK, 1'b1));
    void'(push_item(pocs_pkg::REQ_BEGIN, 1'b0));
    void'(push_item(pocs_pkg::REQ_BEGIN, 1'b1));
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b0));
    void'(push_item(pocs_pkg::REQ_TICK, 1'b1));
    void'(push_item(pocs_pkg::REQ_TICK, 1'b0));
    push_ticks(3, 1'b0);
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b0));
    void'(push_item(pocs_pkg::REQ_RSVD, 1'b0));
    push_ticks(4, 1'b1);
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b1));
    push_ticks(2, 1'b0);
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b0));
    drain_to_idle();
    void'(push_item(pocs_pkg::REQ_BEGIN, 1'b1));
    void'(push_item(pocs_pkg::REQ_TICK, 1'b0));
    push_ticks(3, 1'b1);
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b0));
    push_ticks(3, 1'b0);
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b1));
    push_ticks(3, 1'b1);
    void'(push_item(pocs_pkg::REQ_CLICK, 1'b0));
    drain_to_idle();

    write_regs(2, 6, 9, 3);
    run_random(35);
    drain_to_idle();
    // zero timeout and delay, window that admits nothing
    write_regs(0, 1, 0, 0);
    run_random(35);
    drain_to_idle();
    write_regs(0, 16'hFFFF, 7, 5);
    run_random(35);
    drain_to_idle();

    send_idle_pct = 46;
    recv_idle_pct = 33;
    write_regs(3, 4, 6, 2);
    run_random(35);
    drain_to_idle();
    write_regs(16'hFFFF, 16'hFFFF, 4, 16'hFFFF);
    run_random(35);
    drain_to_idle();
    write_regs(0, 3, 5, 1);
    run_random(35);
    drain_to_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_regs(1, 10, 12, 0);
    run_random(45);
    // hold the receiver off while the queue is full of items
    hold_requests++;
    drain_to_idle();
    repeat (2) begin
      lo = $urandom_range(6);
      write_regs(16'(lo), 16'(lo + $urandom_range(8)), 16'($urandom_range(14)),
                 16'($urandom_range(6)));
      run_random(35);
      drain_to_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** power_off_click_sequence_top: PASSED **");
    end else begin
      $display("** power_off_click_sequence_top: FAILED **");
    end
    $finish;
  end

endmodule
